// ===== hw/rtl/mfep_pkg.sv =====
package mfep_pkg;

  typedef enum logic [16:0] {
    PH_HDR_TAG   = 17'h00001,
    PH_HDR_LEN   = 17'h00002,
    PH_HDR_FMT   = 17'h00004,
    PH_HDR_TRK   = 17'h00008,
    PH_HDR_DIV   = 17'h00010,
    PH_HDR_SKIP  = 17'h00020,
    PH_TRK_TAG   = 17'h00040,
    PH_TRK_LEN   = 17'h00080,
    PH_DELTA     = 17'h00100,
    PH_STATUS    = 17'h00200,
    PH_META_TYPE = 17'h00400,
    PH_META_LEN1 = 17'h00800,
    PH_LEN_VLQ   = 17'h01000,
    PH_SKIP      = 17'h02000,
    PH_DATA1     = 17'h04000,
    PH_DATA2     = 17'h08000,
    PH_ERROR     = 17'h10000
  } phase_t;

  typedef enum logic [1:0] {
    RK_CHANNEL = 2'd0,
    RK_HEADER  = 2'd1,
    RK_ERROR   = 2'd2
  } result_kind_t;

  typedef enum logic [2:0] {
    ERR_BAD_MTHD   = 3'd0,
    ERR_BAD_MTRK   = 3'd1,
    ERR_SHORT_HDR  = 3'd2,
    ERR_BAD_FORMAT = 3'd3,
    ERR_BAD_STATUS = 3'd4,
    ERR_LONG_VLQ   = 3'd5
  } error_code_t;

  localparam logic [31:0] TAG_HEAD  = 32'h4D546864;
  localparam logic [31:0] TAG_TRACK = 32'h4D54726B;
  localparam logic [31:0] HDR_MIN_LEN = 32'd6;

  localparam logic [7:0] ST_META   = 8'hFF;
  localparam logic [7:0] ST_SYSEX  = 8'hF0;
  localparam logic [7:0] ST_ESCAPE = 8'hF7;
  localparam logic [3:0] NIB_PROGRAM  = 4'hC;
  localparam logic [3:0] NIB_CHAN_PRS = 4'hD;

  localparam logic [7:0] META_SEQ_NUM  = 8'h00;
  localparam logic [7:0] META_CH_PFX   = 8'h20;
  localparam logic [7:0] META_END_TRK  = 8'h2F;
  localparam logic [7:0] META_TEMPO    = 8'h51;
  localparam logic [7:0] META_SMPTE    = 8'h54;
  localparam logic [7:0] META_TIME_SIG = 8'h58;
  localparam logic [7:0] META_KEY_SIG  = 8'h59;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [27:0] delta_time;
    logic [2:0]  event_kind;
    logic [3:0]  channel_number;
    logic [7:0]  data_first;
    logic [7:0]  data_second;
    logic [1:0]  file_format;
    logic [15:0] track_count;
    logic [15:0] ticks_per_quarter;
    logic [2:0]  error_code;
  } result_t;

  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0: r = tag[31:24];
      2'd1: r = tag[23:16];
      2'd2: r = tag[15:8];
      default: r = tag[7:0];
    endcase
    return r;
  endfunction

  function automatic logic meta_short_len(input logic [7:0] b);
    return (b == META_SEQ_NUM) || (b == META_CH_PFX) || (b == META_END_TRK) ||
           (b == META_TEMPO) || (b == META_SMPTE) || (b == META_TIME_SIG) ||
           (b == META_KEY_SIG);
  endfunction

endpackage

// ===== hw/rtl/mfep_in_stage.sv =====
module mfep_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] byte_value,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  assign in_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_byte <= byte_value;
    end
  end

endmodule

// ===== hw/rtl/mfep_core.sv =====
module mfep_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [7:0]       b,
  output logic             emit,
  output mfep_pkg::result_t result
);
  import mfep_pkg::*;

  phase_t      parse_phase, parse_phase_next;
  logic [2:0]  field_byte_index, field_byte_index_next;
  logic [31:0] shift_accumulator, shift_accumulator_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [31:0] bytes_consumed, bytes_consumed_next;
  logic [31:0] skip_remaining, skip_remaining_next;
  logic [27:0] vlq_value, vlq_value_next;
  logic [2:0]  vlq_byte_count, vlq_byte_count_next;
  logic [7:0]  latched_status, latched_status_next;
  logic [7:0]  latched_data, latched_data_next;
  logic [1:0]  header_format, header_format_next;
  logic [15:0] header_tracks, header_tracks_next;

  logic [31:0] acc_shift;
  logic [2:0]  idx_inc;
  logic [27:0] vlq_shift;
  logic [2:0]  vlq_cnt_inc;
  logic        do_end;
  logic        do_skip;
  logic [31:0] skip_len;
  logic        track_phase;

  always_comb begin
    acc_shift   = {shift_accumulator[23:0], b};
    idx_inc     = field_byte_index + 3'd1;
    vlq_shift   = {vlq_value[20:0], b[6:0]};
    vlq_cnt_inc = vlq_byte_count + 3'd1;
    track_phase = (parse_phase == PH_DELTA) || (parse_phase == PH_STATUS) ||
                  (parse_phase == PH_META_TYPE) || (parse_phase == PH_META_LEN1) ||
                  (parse_phase == PH_LEN_VLQ) || (parse_phase == PH_SKIP) ||
                  (parse_phase == PH_DATA1) || (parse_phase == PH_DATA2);

    parse_phase_next       = parse_phase;
    field_byte_index_next  = field_byte_index;
    shift_accumulator_next = shift_accumulator;
    chunk_length_next      = chunk_length;
    bytes_consumed_next    = track_phase ? bytes_consumed + 32'd1 : bytes_consumed;
    skip_remaining_next    = skip_remaining;
    vlq_value_next         = vlq_value;
    vlq_byte_count_next    = vlq_byte_count;
    latched_status_next    = latched_status;
    latched_data_next      = latched_data;
    header_format_next     = header_format;
    header_tracks_next     = header_tracks;
    do_end   = 1'b0;
    do_skip  = 1'b0;
    skip_len = 32'd0;
    emit     = 1'b0;
    result   = '0;

    case (parse_phase)
      PH_HDR_TAG, PH_TRK_TAG: begin
        if (b != tag_byte((parse_phase == PH_HDR_TAG) ? TAG_HEAD : TAG_TRACK,
                          field_byte_index[1:0])) begin
          emit = 1'b1;
          result.result_kind = RK_ERROR;
          result.error_code = (parse_phase == PH_HDR_TAG) ? ERR_BAD_MTHD : ERR_BAD_MTRK;
          parse_phase_next = PH_ERROR;
        end else if (idx_inc >= 3'd4) begin
          field_byte_index_next  = 3'd0;
          shift_accumulator_next = 32'd0;
          parse_phase_next = (parse_phase == PH_HDR_TAG) ? PH_HDR_LEN : PH_TRK_LEN;
        end else begin
          field_byte_index_next = idx_inc;
        end
      end
      PH_HDR_LEN: begin
        shift_accumulator_next = acc_shift;
        field_byte_index_next  = idx_inc;
        if (idx_inc >= 3'd4) begin
          field_byte_index_next = 3'd0;
          chunk_length_next = acc_shift;
          if (acc_shift < HDR_MIN_LEN) begin
            emit = 1'b1;
            result.result_kind = RK_ERROR;
            result.error_code = ERR_SHORT_HDR;
            parse_phase_next = PH_ERROR;
          end else begin
            shift_accumulator_next = 32'd0;
            parse_phase_next = PH_HDR_FMT;
          end
        end
      end
      PH_HDR_FMT: begin
        shift_accumulator_next = acc_shift;
        field_byte_index_next  = idx_inc;
        if (idx_inc >= 3'd2) begin
          field_byte_index_next = 3'd0;
          if (acc_shift[15:0] > 16'd2) begin
            emit = 1'b1;
            result.result_kind = RK_ERROR;
            result.error_code = ERR_BAD_FORMAT;
            parse_phase_next = PH_ERROR;
          end else begin
            header_format_next = acc_shift[1:0];
            shift_accumulator_next = 32'd0;
            parse_phase_next = PH_HDR_TRK;
          end
        end
      end
      PH_HDR_TRK: begin
        shift_accumulator_next = acc_shift;
        field_byte_index_next  = idx_inc;
        if (idx_inc >= 3'd2) begin
          field_byte_index_next  = 3'd0;
          header_tracks_next     = acc_shift[15:0];
          shift_accumulator_next = 32'd0;
          parse_phase_next = PH_HDR_DIV;
        end
      end
      PH_HDR_DIV: begin
        shift_accumulator_next = acc_shift;
        field_byte_index_next  = idx_inc;
        if (idx_inc >= 3'd2) begin
          field_byte_index_next = 3'd0;
          emit = 1'b1;
          result.result_kind = RK_HEADER;
          result.file_format = header_format;
          result.track_count = header_tracks;
          result.ticks_per_quarter = acc_shift[15:0];
          if (chunk_length > HDR_MIN_LEN) begin
            skip_remaining_next = chunk_length - HDR_MIN_LEN;
            parse_phase_next = PH_HDR_SKIP;
          end else begin
            parse_phase_next = PH_TRK_TAG;
          end
        end
      end
      PH_HDR_SKIP: begin
        skip_remaining_next = skip_remaining - 32'd1;
        if (skip_remaining == 32'd1) begin
          parse_phase_next = PH_TRK_TAG;
          field_byte_index_next = 3'd0;
        end
      end
      PH_TRK_LEN: begin
        shift_accumulator_next = acc_shift;
        field_byte_index_next  = idx_inc;
        if (idx_inc >= 3'd4) begin
          field_byte_index_next = 3'd0;
          chunk_length_next = acc_shift;
          bytes_consumed_next = 32'd0;
          do_end = 1'b1;
        end
      end
      PH_DELTA, PH_LEN_VLQ: begin
        vlq_value_next = vlq_shift;
        vlq_byte_count_next = vlq_cnt_inc;
        if (b[7]) begin
          if (vlq_cnt_inc >= 3'd4) begin
            emit = 1'b1;
            result.result_kind = RK_ERROR;
            result.error_code = ERR_LONG_VLQ;
            parse_phase_next = PH_ERROR;
          end
        end else if (parse_phase == PH_DELTA) begin
          parse_phase_next = PH_STATUS;
        end else begin
          do_skip = 1'b1;
          skip_len = {4'd0, vlq_shift};
        end
      end
      PH_STATUS: begin
        if (b == ST_META) begin
          parse_phase_next = PH_META_TYPE;
        end else if (b == ST_SYSEX || b == ST_ESCAPE) begin
          vlq_value_next = 28'd0;
          vlq_byte_count_next = 3'd0;
          parse_phase_next = PH_LEN_VLQ;
        end else if (b[7] && b < ST_SYSEX) begin
          latched_status_next = b;
          parse_phase_next = PH_DATA1;
        end else begin
          emit = 1'b1;
          result.result_kind = RK_ERROR;
          result.error_code = ERR_BAD_STATUS;
          parse_phase_next = PH_ERROR;
        end
      end
      PH_META_TYPE: begin
        if (meta_short_len(b)) begin
          parse_phase_next = PH_META_LEN1;
        end else begin
          vlq_value_next = 28'd0;
          vlq_byte_count_next = 3'd0;
          parse_phase_next = PH_LEN_VLQ;
        end
      end
      PH_META_LEN1: begin
        do_skip = 1'b1;
        skip_len = {24'd0, b};
      end
      PH_SKIP: begin
        skip_remaining_next = skip_remaining - 32'd1;
        if (skip_remaining == 32'd1) begin
          do_end = 1'b1;
        end
      end
      PH_DATA1, PH_DATA2: begin
        if (parse_phase == PH_DATA1) begin
          latched_data_next = b;
        end
        if (parse_phase == PH_DATA2 || latched_status[7:4] == NIB_PROGRAM ||
            latched_status[7:4] == NIB_CHAN_PRS) begin
          emit = 1'b1;
          result.result_kind = RK_CHANNEL;
          result.delta_time = vlq_value;
          result.event_kind = latched_status[6:4];
          result.channel_number = latched_status[3:0];
          result.data_first = (parse_phase == PH_DATA1) ? b : latched_data;
          result.data_second = (parse_phase == PH_DATA2) ? b : 8'd0;
          do_end = 1'b1;
        end else begin
          parse_phase_next = PH_DATA2;
        end
      end
      default: begin
        bytes_consumed_next = bytes_consumed;
      end
    endcase

    if (do_skip) begin
      if (skip_len == 32'd0) begin
        do_end = 1'b1;
      end else begin
        skip_remaining_next = skip_len;
        parse_phase_next = PH_SKIP;
      end
    end

    if (do_end) begin
      if (bytes_consumed_next >= chunk_length_next) begin
        parse_phase_next = PH_TRK_TAG;
        field_byte_index_next = 3'd0;
      end else begin
        vlq_value_next = 28'd0;
        vlq_byte_count_next = 3'd0;
        parse_phase_next = PH_DELTA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= PH_HDR_TAG;
      field_byte_index  <= 3'd0;
      shift_accumulator <= 32'd0;
      chunk_length      <= 32'd0;
      bytes_consumed    <= 32'd0;
      skip_remaining    <= 32'd0;
      vlq_value         <= 28'd0;
      vlq_byte_count    <= 3'd0;
      latched_status    <= 8'd0;
      latched_data      <= 8'd0;
      header_format     <= 2'd0;
      header_tracks     <= 16'd0;
    end else if (advance) begin
      parse_phase       <= parse_phase_next;
      field_byte_index  <= field_byte_index_next;
      shift_accumulator <= shift_accumulator_next;
      chunk_length      <= chunk_length_next;
      bytes_consumed    <= bytes_consumed_next;
      skip_remaining    <= skip_remaining_next;
      vlq_value         <= vlq_value_next;
      vlq_byte_count    <= vlq_byte_count_next;
      latched_status    <= latched_status_next;
      latched_data      <= latched_data_next;
      header_format     <= header_format_next;
      header_tracks     <= header_tracks_next;
    end
  end

endmodule

// ===== hw/rtl/mfep_out_reg.sv =====
module mfep_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             emit,
  input  mfep_pkg::result_t result,
  input  logic             out_stall,
  output logic             room,
  output logic             out_valid,
  output mfep_pkg::result_t held
);
  import mfep_pkg::*;

  assign room = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (room && advance && emit) begin
      held <= result;
    end
  end

endmodule

// ===== hw/rtl/midi_file_event_parser.sv =====
// Standard MIDI File parser: feed the file one byte per input transaction. The
// block checks the MThd header, emits one header result (format, track count,
// ticks per quarter), then walks MTrk chunks and emits one result per channel
// event (note on/off, pressure, controller, program, pitch bend) with its delta
// time. Sysex and meta events are skipped; running status is not supported. On
// any error a single error result is emitted and all further bytes are
// swallowed until reset. One parse state machine handles every byte; a new
// byte is accepted every cycle unless out_stall holds a full result register.
// A byte goes from an input register through the parser to a result register.
module midi_file_event_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [27:0] delta_time,
  output logic [2:0]  event_kind,
  output logic [3:0]  channel_number,
  output logic [7:0]  data_first,
  output logic [7:0]  data_second,
  output logic [1:0]  file_format,
  output logic [15:0] track_count,
  output logic [15:0] ticks_per_quarter,
  output logic [2:0]  error_code
);
  import mfep_pkg::*;

  logic       held_valid;
  logic [7:0] held_byte;
  logic       advance;
  logic       room;
  logic       emit;
  result_t    result;
  result_t    held;

  assign advance = held_valid && room;

  mfep_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_value (byte_value),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  mfep_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .b       (held_byte),
    .emit    (emit),
    .result  (result)
  );

  mfep_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .emit      (emit),
    .result    (result),
    .out_stall (out_stall),
    .room      (room),
    .out_valid (out_valid),
    .held      (held)
  );

  assign result_kind       = held.result_kind;
  assign delta_time        = held.delta_time;
  assign event_kind        = held.event_kind;
  assign channel_number    = held.channel_number;
  assign data_first        = held.data_first;
  assign data_second       = held.data_second;
  assign file_format       = held.file_format;
  assign track_count       = held.track_count;
  assign ticks_per_quarter = held.ticks_per_quarter;
  assign error_code        = held.error_code;

endmodule
